// File: hdl/itap_pkg.sv
// Shared types and constants of the IPv4 text address parser.
`default_nettype none

package itap_pkg;

  // Field widths of the channels.
  localparam int unsigned CharW    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHostOrderSwap    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgRejectLeadZeros  = 8'd1;

  // Result status codes; ErrSoft doubles as the internal soft-failure mark.
  localparam logic [StatusW-1:0] StOk          = 4'd0;
  localparam logic [StatusW-1:0] StNameLookup  = 4'd1;
  localparam logic [StatusW-1:0] StGarbage     = 4'd2;
  localparam logic [StatusW-1:0] StSyntax      = 4'd3;
  localparam logic [StatusW-1:0] StNonNumeric  = 4'd4;
  localparam logic [StatusW-1:0] StOverflow    = 4'd5;
  localparam logic [StatusW-1:0] StHex         = 4'd6;
  localparam logic [StatusW-1:0] StOctal       = 4'd7;
  localparam logic [StatusW-1:0] StBadHex      = 4'd8;
  localparam logic [StatusW-1:0] StUnprintable = 4'd9;
  localparam logic [StatusW-1:0] StIllegal     = 4'd10;
  localparam logic [StatusW-1:0] ErrNone       = 4'd0;
  localparam logic [StatusW-1:0] ErrSoft       = 4'd1;

  // Character constants.
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChLowH  = 8'h68;
  localparam logic [CharW-1:0] ChUpH   = 8'h48;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTilde = 8'h7E;

  localparam logic [7:0] OctetMax   = 8'd255;
  localparam logic [3:0] CountSat   = 4'd11;
  localparam logic [3:0] HexLen     = 4'd10;
  localparam logic [3:0] HexLastPos = 4'd9;

  typedef enum logic [1:0] {
    KindNone,
    KindX,
    KindH,
    KindZero
  } hex_kind_e;

  typedef enum logic {
    PhStart,
    PhDigits
  } phase_e;

  typedef struct packed {
    logic nul;
    logic unprint;
    logic illegal;
  } name_flags_t;

endpackage

`default_nettype wire

// File: hdl/itap_intf.sv
// Channel interfaces of the IPv4 text address parser.
`default_nettype none

interface itap_char_if;
  logic                          valid;
  logic                          ready;
  logic [itap_pkg::CharW-1:0]    char_code;
  logic                          last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface itap_result_if;
  logic                          valid;
  logic                          ready;
  logic [itap_pkg::AddrW-1:0]    address;
  logic [itap_pkg::StatusW-1:0]  status;

  modport source (output valid, address, status, input ready);
  modport sink (input valid, address, status, output ready);
endinterface

interface itap_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [itap_pkg::CfgIdxW-1:0]  reg_index;
  logic [itap_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: hdl/ipv4_text_address_parser_top.sv
// Top level of the IPv4 text address parser.
//
// Usage: the address text arrives on char_i, one character per transfer,
// with last_char set on the final character. After the final character the
// parsed address and a status appear on res_o; no result is produced for
// other characters. Dotted decimal (one to four components), 0x and 0h
// hex forms are recognized; a soft dotted failure falls back to a name
// character check: unprintable, illegal or "name needs lookup".
// Configuration writes arrive on cfg_i (always ready) and are to be made
// only while no string is in progress.
// Latency: the result is valid in the cycle after the final character's
// transfer. Throughput: one character per cycle; every character is folded
// into the per-string state in the cycle of its transfer.
// When the receiver stalls, the result register holds, and char_i stays
// ready for characters until a further final character would need it.
// Reset clears the string state, empties the result register and sets
// host_order_swap to 1 and reject_leading_zeros to 0.
`default_nettype none

module ipv4_text_address_parser_top (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  itap_char_if.sink    char_i,
  itap_result_if.source res_o,
  itap_cfg_if.sink     cfg_i
);

  // Configuration registers.
  logic swap_q;
  logic rlz_q;

  // Per-string state.
  logic [2:0]                  idx_q, idx_d;
  logic [8:0]                  cv_q, cv_d;
  logic [31:0]                 acc_q, acc_d;
  itap_pkg::phase_e            phase_q, phase_d;
  logic [3:0]                  err_q, err_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [31:0]                 hex_q, hex_d;
  itap_pkg::hex_kind_e         kind_q, kind_d;
  logic                        hbad_q, hbad_d;
  itap_pkg::name_flags_t       nf_q, nf_d;
  logic                        sz_q, sz_d;

  // Result register.
  logic                        ovalid_q, ovalid_d;
  logic [31:0]                 addr_q, addr_d;
  logic [3:0]                  stat_q, stat_d;

  logic       in_fire;
  logic [7:0] c;
  logic       digit;
  logic [3:0] dval;
  logic [3:0] hexv;
  logic       hexok;
  logic       namech;
  logic [11:0] prod;
  logic [31:0] acc_fin;
  logic [2:0]  idx_fin;
  logic [31:0] addr_r;
  logic [3:0]  stat_r;

  // Only a final character needs the result register, so other characters
  // keep flowing while a result waits.
  assign char_i.ready = !ovalid_q || res_o.ready || !char_i.last_char;
  assign in_fire      = char_i.valid && char_i.ready;
  assign c            = char_i.char_code;
  assign cfg_i.ready  = 1'b1;

  assign res_o.valid   = ovalid_q;
  assign res_o.address = addr_q;
  assign res_o.status  = stat_q;

  assign digit = (c >= itap_pkg::ChZero) && (c <= itap_pkg::ChNine);
  assign dval  = c[3:0];
  assign prod  = 12'(cv_q) * 12'd10 + 12'(dval);

  assign namech = ((c >= itap_pkg::ChLowA) && (c <= itap_pkg::ChLowZ)) ||
                  ((c >= itap_pkg::ChUpA) && (c <= itap_pkg::ChUpZ)) || digit ||
                  (c == itap_pkg::ChDash) || (c == itap_pkg::ChUnder) ||
                  (c == itap_pkg::ChDot);

  always_comb begin
    hexok = 1'b1;
    hexv  = 4'd0;
    if (digit) begin
      hexv = c[3:0];
    end else if ((c >= itap_pkg::ChLowA && c <= itap_pkg::ChLowF) ||
                 (c >= itap_pkg::ChUpA && c <= itap_pkg::ChUpF)) begin
      // Letters a-f and A-F share their low nibble: 1..6 maps to 10..15.
      hexv = c[3:0] + 4'd9;
    end else begin
      hexok = 1'b0;
    end
  end

  // Per-character update of the string state, then the end-of-string result.
  always_comb begin
    idx_d   = idx_q;
    cv_d    = cv_q;
    acc_d   = acc_q;
    phase_d = phase_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    hex_d   = hex_q;
    kind_d  = kind_q;
    hbad_d  = hbad_q;
    nf_d    = nf_q;
    sz_d    = sz_q;
    ovalid_d = ovalid_q && !res_o.ready;
    addr_d  = addr_q;
    stat_d  = stat_q;
    acc_fin = 32'd0;
    idx_fin = 3'd0;
    addr_r  = 32'd0;
    stat_r  = itap_pkg::StOk;

    if (in_fire) begin
      if (cnt_q < itap_pkg::CountSat) begin
        cnt_d = cnt_q + 4'd1;
      end

      // Hex form tracking.
      if (cnt_q == 4'd0) begin
        kind_d = (c == itap_pkg::ChZero) ? itap_pkg::KindZero : itap_pkg::KindNone;
      end else if (cnt_q == 4'd1) begin
        if (kind_q == itap_pkg::KindZero && (c == itap_pkg::ChLowX || c == itap_pkg::ChUpX)) begin
          kind_d = itap_pkg::KindX;
        end else if (kind_q == itap_pkg::KindZero &&
                     (c == itap_pkg::ChLowH || c == itap_pkg::ChUpH)) begin
          kind_d = itap_pkg::KindH;
        end else begin
          kind_d = itap_pkg::KindNone;
        end
      end else if (cnt_q <= itap_pkg::HexLastPos) begin
        hex_d = {hex_q[27:0], hexv};
        if (!hexok) begin
          hbad_d = 1'b1;
        end
      end

      // Name character flags; unprintable only counts before a zero byte.
      if (c == 8'd0) begin
        nf_d.nul = 1'b1;
      end else if (!nf_q.nul && (c < itap_pkg::ChSpace || c > itap_pkg::ChTilde)) begin
        nf_d.unprint = 1'b1;
      end
      if (!namech) begin
        nf_d.illegal = 1'b1;
      end

      // Dotted decimal parsing stops at the first error.
      if (err_q == itap_pkg::ErrNone) begin
        if (phase_q == itap_pkg::PhStart) begin
          if (digit) begin
            cv_d    = 9'(dval);
            sz_d    = (c == itap_pkg::ChZero);
            phase_d = itap_pkg::PhDigits;
          end else begin
            err_d = (idx_q > 3'd1) ? itap_pkg::StNonNumeric : itap_pkg::ErrSoft;
          end
        end else begin
          sz_d = 1'b0;
          if (sz_q && (c == itap_pkg::ChLowX || c == itap_pkg::ChUpX) &&
              !char_i.last_char) begin
            err_d = itap_pkg::StHex;
          end else if (digit) begin
            if (sz_q && rlz_q) begin
              err_d = itap_pkg::StOctal;
            end else if (prod > 12'(itap_pkg::OctetMax)) begin
              cv_d  = 9'd256;
              err_d = itap_pkg::StOverflow;
            end else begin
              cv_d = prod[8:0];
            end
          end else begin
            acc_d   = {acc_q[23:0], cv_q[7:0]};
            idx_d   = idx_q + 3'd1;
            cv_d    = 9'd0;
            phase_d = itap_pkg::PhStart;
            if (idx_q < 3'd3) begin
              if (c != itap_pkg::ChDot) begin
                err_d = (idx_q == 3'd0) ? itap_pkg::ErrSoft : itap_pkg::StSyntax;
              end
            end else begin
              err_d = itap_pkg::StGarbage;
            end
          end
        end
      end

      if (char_i.last_char) begin
        // Close an open component, then left-align the octets present.
        acc_fin = acc_d;
        idx_fin = idx_d;
        if (phase_d == itap_pkg::PhDigits) begin
          acc_fin = {acc_d[23:0], cv_d[7:0]};
          idx_fin = idx_d + 3'd1;
        end

        if (cnt_d == itap_pkg::HexLen &&
            (kind_d == itap_pkg::KindX || kind_d == itap_pkg::KindH)) begin
          if (hbad_d) begin
            stat_r = itap_pkg::StBadHex;
          end else if (kind_d == itap_pkg::KindH && swap_q) begin
            addr_r = {hex_d[7:0], hex_d[15:8], hex_d[23:16], hex_d[31:24]};
          end else begin
            addr_r = hex_d;
          end
        end else if (err_d == itap_pkg::ErrNone) begin
          case (idx_fin)
            3'd1:    addr_r = {acc_fin[7:0], 24'd0};
            3'd2:    addr_r = {acc_fin[15:0], 16'd0};
            3'd3:    addr_r = {acc_fin[23:0], 8'd0};
            3'd0:    addr_r = 32'd0;
            default: addr_r = acc_fin;
          endcase
        end else if (err_d == itap_pkg::ErrSoft) begin
          if (nf_d.unprint) begin
            stat_r = itap_pkg::StUnprintable;
          end else if (nf_d.illegal) begin
            stat_r = itap_pkg::StIllegal;
          end else begin
            stat_r = itap_pkg::StNameLookup;
          end
        end else begin
          stat_r = err_d;
        end

        ovalid_d = 1'b1;
        addr_d   = (stat_r == itap_pkg::StOk) ? addr_r : 32'd0;
        stat_d   = stat_r;

        // Back to the start-of-string state.
        idx_d   = 3'd0;
        cv_d    = 9'd0;
        acc_d   = 32'd0;
        phase_d = itap_pkg::PhStart;
        err_d   = itap_pkg::ErrNone;
        cnt_d   = 4'd0;
        hex_d   = 32'd0;
        kind_d  = itap_pkg::KindNone;
        hbad_d  = 1'b0;
        nf_d    = '0;
        sz_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q   <= 1'b1;
      rlz_q    <= 1'b0;
      idx_q    <= 3'd0;
      cv_q     <= 9'd0;
      acc_q    <= 32'd0;
      phase_q  <= itap_pkg::PhStart;
      err_q    <= itap_pkg::ErrNone;
      cnt_q    <= 4'd0;
      hex_q    <= 32'd0;
      kind_q   <= itap_pkg::KindNone;
      hbad_q   <= 1'b0;
      nf_q     <= '0;
      sz_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.reg_index == itap_pkg::CfgHostOrderSwap) begin
          swap_q <= cfg_i.wdata[0];
        end else if (cfg_i.reg_index == itap_pkg::CfgRejectLeadZeros) begin
          rlz_q <= cfg_i.wdata[0];
        end
      end
      idx_q    <= idx_d;
      cv_q     <= cv_d;
      acc_q    <= acc_d;
      phase_q  <= phase_d;
      err_q    <= err_d;
      cnt_q    <= cnt_d;
      hex_q    <= hex_d;
      kind_q   <= kind_d;
      hbad_q   <= hbad_d;
      nf_q     <= nf_d;
      sz_q     <= sz_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    stat_q <= stat_d;
  end

  // A final character always leaves a result behind it.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && char_i.last_char) |=> ovalid_q)
    else $error("final character did not produce a result");

  // Any failure status carries a zero address.
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && stat_q != itap_pkg::StOk) |-> (addr_q == 32'd0))
    else $error("nonzero address with an error status");

  // The string state starts over after each final character.
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && char_i.last_char) |=>
      (cnt_q == 4'd0 && err_q == itap_pkg::ErrNone && idx_q == 3'd0))
    else $error("string state not cleared after the final character");

  // A result waiting on a stalled receiver is not overwritten.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !res_o.ready) |=> (ovalid_q && $stable(addr_q) && $stable(stat_q)))
    else $error("pending result changed while stalled");

  // Every reported status lies within the defined codes, up to StIllegal.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (stat_q <= itap_pkg::StIllegal))
    else $error("status code out of range");

endmodule

`default_nettype wire
